>>> rtl/wbkc_pkg.sv
// ----------------------------------------------------------------------------
// wbkc_pkg
// shared types, constants and helpers of the whole-word keyword counter
// ----------------------------------------------------------------------------
`default_nettype none

package wbkc_pkg;

    localparam int KEYWORDS    = 4;
    localparam int KW_BYTES    = 8;
    localparam int WIN_DEPTH   = KW_BYTES + 1;
    localparam int COUNT_WIDTH = 16;
    localparam int LEN_W       = 4;
    localparam int POS_W       = $clog2(KW_BYTES);
    localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
    localparam int INC_W       = 2;
    localparam int SUM_W       = $clog2(2 * KEYWORDS + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8 * KW_BYTES;
    localparam int TAG_W       = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_KW_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KW_B    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KW_C    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KW_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS = 3'd4;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    typedef struct packed {
        logic [7:0]       content_byte;
        logic [TAG_W-1:0] chunk_tag;
        logic             last_byte;
    } t_in_req;

    typedef struct packed {
        logic [TAG_W-1:0]       tag_out;
        logic [COUNT_WIDTH-1:0] match_count;
    } t_out_req;

    // one stage of the byte window
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_win_slot;

    // keyword bytes lined up with one window position
    typedef struct packed {
        logic [KEYWORDS-1:0]      used;
        logic [KEYWORDS-1:0][7:0] data;
    } t_cell_key;

    // per-keyword controls handed to a tracker
    typedef struct packed {
        logic             accept;
        logic             last;
        logic             hit;
        logic             left_ok;
        logic             cur_word;
        logic [POS_W-1:0] len_m1;
    } t_track_ctl;

    function automatic logic f_is_word(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h61 && b <= 8'h7A) || (b == CHAR_UNDERSCORE);
    endfunction

    // keyword byte that must sit at window position pos for a match ending now
    function automatic logic [7:0] f_align(input logic [CFG_DATA_W-1:0] word,
                                           input logic [LEN_W-1:0]      len,
                                           input logic [POS_W-1:0]      pos);
        logic [POS_W-1:0] idx;
        idx = len[POS_W-1:0] - POS_W'(1) - pos;
        return word[8*idx +: 8];
    endfunction

endpackage

`default_nettype wire

>>> rtl/word_bounded_keyword_counter_core.sv
// ----------------------------------------------------------------------------
// word_bounded_keyword_counter_core
// counts whole-word matches of up to four keywords per tagged chunk
// ----------------------------------------------------------------------------
// One content byte is taken per clock while o_in_stall is low: the byte
// is compared against all keywords in the cycle it is accepted and the
// per-chunk state is updated at the same edge. Each of the eight window
// cells compares the byte it is about to take with the keyword byte lined
// up for its position. A result request (chunk tag and saturated count) is
// registered in the output register, or in the skid buffer while the output
// is held, when the last byte of a chunk whose count is nonzero is accepted.
// Results sit in an output register backed by a one-entry skid buffer, so
// input keeps flowing while a result waits; o_in_stall is raised only when
// both are full. Keyword and length registers are loaded through the write
// port and reset to zero, which leaves every keyword disabled. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module word_bounded_keyword_counter_core
    import wbkc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // byte requests
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_req               i_in_data,
    // result requests
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_req                   o_out_data,
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // ---------------- configuration registers ----------------
    logic [KEYWORDS-1:0][CFG_DATA_W-1:0] r_kw;
    logic [KEYWORDS*LEN_W-1:0]           r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw  <= '0;
            r_len <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KW_A:    r_kw[0] <= i_cfg_data;
                CFG_KW_B:    r_kw[1] <= i_cfg_data;
                CFG_KW_C:    r_kw[2] <= i_cfg_data;
                CFG_KW_D:    r_kw[3] <= i_cfg_data;
                CFG_LENGTHS: r_len   <= i_cfg_data[KEYWORDS*LEN_W-1:0];
                default: ; // unknown index, write dropped
            endcase
        end
    end

    // ---------------- request handshake ----------------
    logic r_skid_valid;
    logic w_accept;
    logic w_last;

    assign o_in_stall = r_skid_valid;
    assign w_accept   = i_in_valid && !r_skid_valid;
    assign w_last     = i_in_data.last_byte;

    // ---------------- keyword lengths ----------------
    logic [KEYWORDS-1:0][LEN_W-1:0] w_len;
    logic [KEYWORDS-1:0]            w_en;

    always_comb begin
        for (int k = 0; k < KEYWORDS; k++) begin
            w_len[k] = r_len[LEN_W*k +: LEN_W];
            // zero length or longer than KW_BYTES: never matches
            w_en[k]  = (w_len[k] != '0) && (w_len[k] <= LEN_W'(KW_BYTES));
        end
    end

    // ---------------- cell chain ----------------
    // position p of the window after this byte is shifted in is the byte
    // entering cell p; position 0 is the incoming byte itself
    t_win_slot                     w_prev [KW_BYTES];
    t_win_slot                     w_slot [KW_BYTES];
    t_cell_key                     w_key  [KW_BYTES];
    logic [KEYWORDS-1:0]           w_eq   [KW_BYTES];
    logic [KW_BYTES-1:0]           w_cword;
    logic [WIN_DEPTH-1:0]          w_pos_valid;
    logic [WIN_DEPTH-1:0]          w_pos_word;
    logic [KEYWORDS-1:0][KW_BYTES-1:0] w_eq_kw;

    genvar gp;
    generate
        for (gp = 0; gp < KW_BYTES; gp++) begin : g_cell
            if (gp == 0) begin : g_head
                assign w_prev[gp] = '{valid: 1'b1, data: i_in_data.content_byte};
            end else begin : g_link
                assign w_prev[gp] = w_slot[gp-1];
            end

            always_comb begin
                for (int k = 0; k < KEYWORDS; k++) begin
                    w_key[gp].used[k] = w_en[k] && (LEN_W'(gp) < w_len[k]);
                    w_key[gp].data[k] = f_align(r_kw[k], w_len[k], POS_W'(gp));
                end
            end

            wbkc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_clear (w_last),
                .i_prev  (w_prev[gp]),
                .i_key   (w_key[gp]),
                .o_slot  (w_slot[gp]),
                .o_eq    (w_eq[gp]),
                .o_word  (w_cword[gp])
            );

            assign w_pos_valid[gp] = w_prev[gp].valid;
            assign w_pos_word[gp]  = w_cword[gp];

            for (genvar gk = 0; gk < KEYWORDS; gk++) begin : g_tr
                assign w_eq_kw[gk][gp] = w_eq[gp][gk];
            end
        end
    endgenerate

    // oldest position, only looked at for the left word edge
    assign w_pos_valid[WIN_DEPTH-1] = w_slot[KW_BYTES-1].valid;
    assign w_pos_word[WIN_DEPTH-1]  = f_is_word(w_slot[KW_BYTES-1].data);

    // ---------------- per-keyword trackers ----------------
    t_track_ctl                     w_ctl [KEYWORDS];
    logic [KEYWORDS-1:0][INC_W-1:0] w_inc;

    genvar gk2;
    generate
        for (gk2 = 0; gk2 < KEYWORDS; gk2++) begin : g_kw
            logic [POS_W-1:0]     w_lm1;
            logic [WIN_IDX_W-1:0] w_lidx;

            assign w_lm1  = w_len[gk2][POS_W-1:0] - POS_W'(1);
            assign w_lidx = w_en[gk2] ? WIN_IDX_W'(w_len[gk2]) : '0;

            always_comb begin
                w_ctl[gk2].accept   = w_accept;
                w_ctl[gk2].last     = w_last;
                // whole keyword present and enough bytes seen
                w_ctl[gk2].hit      = w_en[gk2] && w_pos_valid[WIN_IDX_W'(w_lm1)] &&
                                      (&w_eq_kw[gk2]);
                // byte before the match absent or not a word byte
                w_ctl[gk2].left_ok  = !(w_pos_valid[w_lidx] && w_pos_word[w_lidx]);
                w_ctl[gk2].cur_word = w_cword[0];
                w_ctl[gk2].len_m1   = w_lm1;
            end

            wbkc_track u_track (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[gk2]),
                .o_inc   (w_inc[gk2])
            );
        end
    endgenerate

    // ---------------- running total ----------------
    logic [COUNT_WIDTH-1:0] r_total;
    logic [COUNT_WIDTH-1:0] n_total;
    logic [SUM_W-1:0]       w_sum;
    logic [COUNT_WIDTH:0]   w_wide;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < KEYWORDS; k++) begin
            w_sum = w_sum + SUM_W'(w_inc[k]);
        end
        w_wide  = {1'b0, r_total} + (COUNT_WIDTH+1)'(w_sum);
        // saturate at all ones
        n_total = w_wide[COUNT_WIDTH] ? '1 : w_wide[COUNT_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (w_accept) begin
            r_total <= w_last ? '0 : n_total;
        end
    end

    // ---------------- result output with skid ----------------
    logic     w_res_valid;
    t_out_req w_res;
    logic     w_move;
    logic     r_out_valid;
    t_out_req r_out;
    t_out_req r_skid;

    assign w_res_valid = w_accept && w_last && (n_total != '0);
    assign w_res       = '{tag_out: i_in_data.chunk_tag, match_count: n_total};
    assign w_move      = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_move) begin
            // skid drains first; no request is taken while it is full
            r_out_valid  <= r_skid_valid || w_res_valid;
            r_skid_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_res_valid) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> rtl/wbkc_cell.sv
// ----------------------------------------------------------------------------
// wbkc_cell
// one window stage: compares the byte it takes against every keyword
// ----------------------------------------------------------------------------
`default_nettype none

module wbkc_cell
    import wbkc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_shift,
    input  wire logic                i_clear,
    input  wire t_win_slot           i_prev,
    input  wire t_cell_key           i_key,
    output t_win_slot                o_slot,
    output logic [KEYWORDS-1:0]      o_eq,
    output logic                     o_word
);

    logic       r_valid;
    logic [7:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid && !i_clear;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_prev.data;
        end
    end

    always_comb begin
        for (int k = 0; k < KEYWORDS; k++) begin
            o_eq[k] = !i_key.used[k] || (i_prev.data == i_key.data[k]);
        end
    end

    assign o_word = f_is_word(i_prev.data);
    assign o_slot = '{valid: r_valid, data: r_data};

endmodule

`default_nettype wire

>>> rtl/wbkc_track.sv
// ----------------------------------------------------------------------------
// wbkc_track
// per-keyword match state: pending right-edge check and overlap blocking
// ----------------------------------------------------------------------------
`default_nettype none

module wbkc_track
    import wbkc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_track_ctl        i_ctl,
    output logic [INC_W-1:0]       o_inc
);

    logic             r_pend;
    logic             n_pend;
    logic [POS_W-1:0] r_skip;
    logic [POS_W-1:0] n_skip;
    logic             inc_pend;
    logic             inc_new;

    always_comb begin
        n_pend   = r_pend;
        n_skip   = r_skip;
        inc_pend = r_pend && !i_ctl.cur_word;
        inc_new  = 1'b0;
        if (i_ctl.accept) begin
            n_pend = 1'b0;
            if (r_skip != '0) begin
                n_skip = r_skip - POS_W'(1);
            end else if (i_ctl.hit) begin
                n_skip = i_ctl.len_m1;
                if (i_ctl.left_ok) begin
                    if (i_ctl.last) begin
                        inc_new = 1'b1;
                    end else begin
                        n_pend = 1'b1;
                    end
                end
            end
            // chunk end clears everything
            if (i_ctl.last) begin
                n_pend = 1'b0;
                n_skip = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_skip <= '0;
        end else begin
            r_pend <= n_pend;
            r_skip <= n_skip;
        end
    end

    assign o_inc = INC_W'(inc_pend) + INC_W'(inc_new);

endmodule

`default_nettype wire

>>> rtl/wbkc_checker.sv
// ----------------------------------------------------------------------------
// wbkc_checker
// port-level checks of the keyword counter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module wbkc_checker
    import wbkc_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire t_in_req               i_in_data,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire t_out_req              o_out_data
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // a zero count is never reported
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.match_count != '0)
        else $error("zero count reported");

    // input stall only with a result waiting at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // a non-final byte into an empty block creates no result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_in_data.last_byte && !o_out_valid
        |=> !o_out_valid)
        else $error("result without chunk end");

    // reset empties both sides
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not empty after reset");

endmodule

bind word_bounded_keyword_counter_core wbkc_checker u_wbkc_checker (.*);

`default_nettype wire
